// File: design/grc_pkg.sv
package grc_pkg;

   // Board geometry
   localparam int MAX_WIDTH  = 64;
   localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Register and result widths fixed by the interface
   localparam int WIDTH_BITS = 7;
   localparam int COUNT_BITS = 64;

   // Width used when comparing a column against the row width
   localparam int CMP_BITS   = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;

   localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = WIDTH_BITS'(6);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [CMP_BITS-1:0]   cmp_type;

endpackage

// File: design/grid_route_counter_unit.sv
// Grid route counter: counts monotone right/down paths over a board with
// obstacles, one cell per beat in raster order.
//
// Request channel (req_): one beat per cell, carrying req_blocked and
// req_board_start. A beat is taken at a clock edge with req_valid high and
// req_stall low. req_board_start marks the origin and restarts the row and
// column position.
// Response channel (rsp_): one beat per request beat, in order, carrying the
// cell's route count, a saturated flag (sum clamped at all ones) and row_end.
// CSR port: csr_wr_en/csr_wr_data write the row width (1..64; 0 acts as 1,
// larger values as 64). Write only while the block is idle.
//
// Each cell passes the compute stage, then the response register. Throughput
// is one cell per clock when not stalled: the row-above line buffer is a
// one-port-read, one-port-write RAM read when the cell is taken and written
// when it leaves the compute stage. When rsp_stall is high the response
// register holds, the compute stage fills behind it, and req_stall rises
// once both are occupied. Reset (synchronous) empties the pipeline, sets
// the width to 6 and treats the next cell as the origin. The line buffer is
// not cleared; every entry a board reads is written by the row before it.
module grid_route_counter_unit
   import grc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_blocked,
   input  logic                  req_board_start,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_BITS-1:0] rsp_route_count,
   output logic                  rsp_saturated,
   output logic                  rsp_row_end,

   input  logic                  csr_wr_en,
   input  logic [WIDTH_BITS-1:0] csr_wr_data
);

   // Configuration
   logic [WIDTH_BITS-1:0] row_width_ff;

   // Raster position for the next cell
   col_type  col_pos_ff, col_pos_in;
   logic     first_row_ff, first_row_in;

   // Compute stage
   logic      s1_valid_ff, s1_valid_in;
   col_type   s1_col_ff;
   logic      s1_blocked_ff;
   logic      s1_first_ff;
   logic      s1_last_ff;
   count_type left_count_ff;

   // Response register
   logic      rsp_valid_ff, rsp_valid_in;
   count_type rsp_count_ff;
   logic      rsp_sat_ff;
   logic      rsp_row_end_ff;

   logic      req_accept;
   logic      s1_advance;
   logic      rsp_free;

   col_type   cur_col;
   logic      cur_first;
   logic      cur_last;
   cmp_type   width_eff;

   count_type above_count;
   count_type s1_count;
   logic      s1_sat;
   logic [COUNT_BITS:0] sum_wide;

   // ---------------------------------------------------------------------
   // Handshake: the response register frees when empty or drained; the
   // compute stage moves into it then; a new cell enters behind.
   // ---------------------------------------------------------------------
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Position tracking at the request side. It depends only on the beat
   // sequence and the width, so it runs ahead of the counts.
   // ---------------------------------------------------------------------
   always_comb begin
      width_eff = CMP_BITS'(row_width_ff);
      if (width_eff == '0) begin
         width_eff = CMP_BITS'(1);
      end else if (width_eff > CMP_BITS'(MAX_WIDTH)) begin
         width_eff = CMP_BITS'(MAX_WIDTH);
      end

      cur_col   = req_board_start ? '0   : col_pos_ff;
      cur_first = req_board_start ? 1'b1 : first_row_ff;
      cur_last  = CMP_BITS'(cur_col) >= (width_eff - CMP_BITS'(1));

      // Wrap to the next row at the row end, else step one column
      if (cur_last) begin
         col_pos_in   = '0;
         first_row_in = 1'b0;
      end else begin
         col_pos_in   = COL_BITS'(CMP_BITS'(cur_col) + CMP_BITS'(1));
         first_row_in = cur_first;
      end
   end

   // ---------------------------------------------------------------------
   // Line buffer. Read at the cell's column when the cell is taken; write
   // its count back when it leaves the compute stage. A read at column c
   // needs the entry written one row earlier, at least two cells back, so
   // that write has always landed; with a one-column row the buffer's read data
   // is never used. No forwarding path is needed.
   // ---------------------------------------------------------------------
   grc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_row_above (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (s1_count),
      .rd_en   (req_accept),
      .rd_addr (cur_col),
      .rd_data (above_count)
   );

   // ---------------------------------------------------------------------
   // Count: blocked and origin give zero, other edge cells give one, inner
   // cells add left and above, clamping at all ones.
   // ---------------------------------------------------------------------
   always_comb begin
      sum_wide = {1'b0, left_count_ff} + {1'b0, above_count};
      s1_sat   = 1'b0;
      if (s1_blocked_ff) begin
         s1_count = '0;
      end else if (s1_col_ff == '0 && s1_first_ff) begin
         s1_count = '0;
      end else if (s1_col_ff == '0 || s1_first_ff) begin
         s1_count = COUNT_BITS'(1);
      end else if (sum_wide[COUNT_BITS]) begin
         s1_count = '1;
         s1_sat   = 1'b1;
      end else begin
         s1_count = sum_wide[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RESET;
         col_pos_ff    <= '0;
         first_row_ff  <= 1'b1;
         left_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            row_width_ff <= csr_wr_data;
         end
         if (req_accept) begin
            col_pos_ff   <= col_pos_in;
            first_row_ff <= first_row_in;
         end
         if (s1_advance) begin
            left_count_ff <= s1_count;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff     <= cur_col;
         s1_blocked_ff <= req_blocked;
         s1_first_ff   <= cur_first;
         s1_last_ff    <= cur_last;
      end
      if (s1_advance) begin
         rsp_count_ff   <= s1_count;
         rsp_sat_ff     <= s1_sat;
         rsp_row_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_route_count = rsp_count_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_row_end     = rsp_row_end_ff;

`ifndef ASSERT_OFF
   // A clamped count is all ones
   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_route_count == '1)
      else $error("saturated response without a clamped count");

   // Back-pressure only when both the compute stage and the response are held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && s1_valid_ff)
      else $error("request stalled with room in the pipeline");

   // A board start places the cell at the origin of the first row
   a_start_origin: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_board_start |=> s1_col_ff == '0 && s1_first_ff)
      else $error("board start did not restart the position");

   // The cell after a row end begins the next row at column zero
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      req_accept && cur_last |=> col_pos_ff == '0 && !first_row_ff)
      else $error("row end did not wrap the column position");
`endif

endmodule

// File: design/grc_ram.sv
module grc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/grid_route_counter_unit_tb.sv
module grid_route_counter_unit_tb
   import grc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no beat on either channel before the run is declared hung.
   localparam int QUIET_LIMIT = 4000;
   // Cycles given to the pipeline to settle at the end.
   localparam int DRAIN_CYCLES = 8;
   // Open board that drives counts past all ones: 33 rows of 40 columns.
   localparam int SAT_WIDTH = 40;
   localparam int SAT_ROWS  = 33;

   typedef struct packed {
      count_type route_count;
      logic      saturated;
      logic      row_end;
   } route_result_type;

   // ------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_blocked = 1'b0;
   logic                  req_board_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COUNT_BITS-1:0] rsp_route_count;
   logic                  rsp_saturated;
   logic                  rsp_row_end;
   logic                  csr_wr_en = 1'b0;
   logic [WIDTH_BITS-1:0] csr_wr_data = '0;

   always #5 clock = ~clock;

   grid_route_counter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_blocked     (req_blocked),
      .req_board_start (req_board_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_route_count (rsp_route_count),
      .rsp_saturated   (rsp_saturated),
      .rsp_row_end     (rsp_row_end),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Route predictor: its own copy of the line buffer, the left count,
   // the column position and the width register.
   // ------------------------------------------------------------------
   logic [WIDTH_BITS-1:0] pred_width = ROW_WIDTH_RESET;
   count_type             above_counts [MAX_WIDTH];
   count_type             prev_count = '0;
   int                    next_col = 0;
   logic                  top_row = 1'b1;

   // Routes still owed by the block, oldest first.
   route_result_type expected_routes [$];

   // Knobs for the idling phases, in percent.
   int   send_idle_pct = 0;
   int   stall_pct = 0;

   // Set by a width write: the next board must open with a start beat so
   // the line buffer is never read where the new width left it unwritten.
   logic must_restart = 1'b0;

   int   mismatches = 0;
   int   cells_sent = 0;
   int   widths_written = 0;
   int   saturated_seen = 0;
   int   quiet_cycles = 0;

   route_result_type want_route;

   function automatic int effective_width();
      int w;
      w = int'(pred_width);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   // Advance the predictor by one cell and return the route it must give.
   function automatic route_result_type predict_route(logic blk, logic start);
      route_result_type    r;
      int                  eff;
      int                  col;
      logic [COUNT_BITS:0] wide_sum;
      eff = effective_width();
      if (start) begin
         next_col = 0;
         top_row  = 1'b1;
      end
      col = next_col;
      if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;

      r.saturated = 1'b0;
      if (blk) begin
         r.route_count = '0;
      end else if (col == 0 && top_row) begin
         // the origin itself has no route into it
         r.route_count = '0;
      end else if (col == 0 || top_row) begin
         // edges count one route regardless of obstacles earlier on the edge
         r.route_count = count_type'(1);
      end else begin
         wide_sum = {1'b0, prev_count} + {1'b0, above_counts[col_type'(col)]};
         if (wide_sum[COUNT_BITS]) begin
            r.route_count = '1;
            r.saturated   = 1'b1;
         end else begin
            r.route_count = wide_sum[COUNT_BITS-1:0];
         end
      end

      above_counts[col_type'(col)] = r.route_count;
      prev_count                   = r.route_count;
      r.row_end                    = (col >= eff - 1);
      if (r.row_end) begin
         next_col = 0;
         top_row  = 1'b0;
      end else begin
         next_col = col + 1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input count_type want,
                                  input count_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
   endtask

   // ------------------------------------------------------------------
   // Response side: check every beat against the oldest expectation and
   // drive a fresh random stall for the next cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_routes.size() == 0) begin
            report_mismatch("unexpected beat", '0, rsp_route_count);
         end else begin
            want_route = expected_routes.pop_front();
            if (rsp_route_count !== want_route.route_count)
               report_mismatch("route_count", want_route.route_count, rsp_route_count);
            if (rsp_saturated !== want_route.saturated)
               report_mismatch("saturated", count_type'(want_route.saturated),
                               count_type'(rsp_saturated));
            if (rsp_row_end !== want_route.row_end)
               report_mismatch("row_end", count_type'(want_route.row_end),
                               count_type'(rsp_row_end));
            if (rsp_saturated === 1'b1) saturated_seen++;
         end
      end
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Watchdog: any beat on either channel resets the quiet count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("** grid_route_counter_unit: FAILED **");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Send one cell; idle first at the phase's rate, then hold the beat
   // until the block takes it, and record the route it must answer.
   task automatic send_cell(input logic blk, input logic start);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_blocked     <= blk;
      req_board_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_routes.push_back(predict_route(blk, start));
      if (start) must_restart = 1'b0;
      cells_sent++;
   endtask

   // Drop valid and hold off until every owed route has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_routes.size() != 0) @(posedge clock);
   endtask

   // Write the row width with the block idle.
   task automatic write_width(input logic [WIDTH_BITS-1:0] w);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pred_width   = w;
      must_restart = 1'b1;
      widths_written++;
   endtask

   // Stream random boards at the current width: mostly whole boards with a
   // start beat and random obstacles, some cut short, some continued
   // without a start, and a few stray restarts in the middle.
   task automatic run_boards(input int n_cells);
      int   sent;
      int   w_eff;
      int   rows;
      int   cells;
      int   density;
      logic start;
      sent = 0;
      while (sent < n_cells) begin
         w_eff = effective_width();
         rows  = (w_eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
         cells = w_eff * rows;
         if ($urandom_range(99) < 15) cells = $urandom_range(1, cells);
         // cut the last board short so the chunk holds its size
         if (cells > n_cells - sent) cells = n_cells - sent;
         case ($urandom_range(3))
            0: density = 0;
            1: density = 10;
            2: density = 30;
            default: density = 60;
         endcase
         for (int i = 0; i < cells; i++) begin
            if (i == 0)
               start = must_restart || ($urandom_range(19) != 0);
            else
               start = ($urandom_range(99) < 2);
            send_cell($urandom_range(99) < density, start);
            sent++;
         end
         // now and then let the block run dry before the next board
         if ($urandom_range(9) == 0) wait_drained();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // After reset, with no start beat, the first cell is the origin. Cover
   // an obstacle on the top edge, a blocked left edge, and a start beat
   // that lands on a blocked origin.
   task automatic test_origin_after_reset();
      logic [5:0] top_obst;
      logic [5:0] second_obst;
      top_obst    = 6'b000010;
      second_obst = 6'b010001;
      for (int c = 0; c < 6; c++) send_cell(top_obst[3'(c)], 1'b0);
      for (int c = 0; c < 6; c++) send_cell(second_obst[3'(c)], 1'b0);
      send_cell(1'b1, 1'b1);
      send_cell(1'b0, 1'b0);
   endtask

   // Width zero acts as one column: every cell ends its row.
   task automatic test_single_column();
      write_width('0);
      send_cell(1'b0, 1'b1);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
   endtask

   // Shrink the width while the first row is part way through: the next
   // cell already lies past the new last column and must close the row.
   task automatic test_shrink_mid_row();
      write_width(WIDTH_BITS'(8));
      send_cell(1'b0, 1'b1);
      for (int c = 1; c < 4; c++) send_cell(1'b0, 1'b0);
      write_width(WIDTH_BITS'(2));
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0);
   endtask

   // One idling phase: several width settings, the first an extreme.
   task automatic test_random_phase(input int idle, input int stall,
                                    input logic [WIDTH_BITS-1:0] first_w,
                                    input int n_cells);
      int                    sent_at_start;
      logic [WIDTH_BITS-1:0] w;
      send_idle_pct = idle;
      stall_pct     = stall;
      sent_at_start = cells_sent;
      w = first_w;
      while (cells_sent - sent_at_start < n_cells) begin
         write_width(w);
         run_boards(15);
         case ($urandom_range(9))
            0: w = '0;
            1: w = WIDTH_BITS'(1);
            2: w = WIDTH_BITS'(MAX_WIDTH);
            3: w = '1;
            4: w = WIDTH_BITS'($urandom_range(MAX_WIDTH + 1, 126));
            default: w = WIDTH_BITS'($urandom_range(2, 12));
         endcase
      end
   endtask

   // A wide open board tall enough for counts to pass all ones, with an
   // occasional obstacle at a random cell.
   task automatic test_saturation_board();
      send_idle_pct = 11;
      stall_pct     = 11;
      write_width(WIDTH_BITS'(SAT_WIDTH));
      for (int i = 0; i < SAT_WIDTH * SAT_ROWS; i++)
         send_cell($urandom_range(255) == 0, i == 0);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) above_counts[col_type'(i)] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_origin_after_reset();
      test_single_column();
      test_shrink_mid_row();

      test_random_phase(0, 0, '1, 45);
      test_random_phase(69, 0, '0, 45);
      test_random_phase(0, 69, WIDTH_BITS'(MAX_WIDTH), 45);
      test_random_phase(11, 11, WIDTH_BITS'(1), 45);
      test_saturation_board();

      // Hold off until every route is back, then let the pipe settle.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_routes.size() != 0) mismatches++;

      $display("sent %0d cells over %0d width settings; %0d clamped counts returned",
               cells_sent, widths_written, saturated_seen);
      $display("idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("** grid_route_counter_unit: PASSED **");
      else
         $display("** grid_route_counter_unit: FAILED **");
      $finish;
   end

endmodule
